// ===== rtl/diamond_square_heightmap_macros.svh =====
// Assertion macros used by the height map RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef DIAMOND_SQUARE_HEIGHTMAP_MACROS_SVH
`define DIAMOND_SQUARE_HEIGHTMAP_MACROS_SVH

// same-cycle implication
`define DSH_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DSH_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dsh_pkg.sv =====
// Shared types, constants and functions of the height map generator.
// No dependencies; used by dsh_ctrl, dsh_dp and the top level.
`default_nettype none

package dsh_pkg;

    localparam int HEIGHT_W  = 17;
    localparam int CALC_W    = 20;
    localparam int ESUM_W    = 19;
    localparam int RCP_W     = 20;
    localparam int RCP_SH    = 21;
    localparam int QUOT_W    = 18;
    localparam int NOISE_LIM = 15;
    localparam int NOISE_W   = 5;

    localparam logic [RCP_W-1:0]  RECIP3    = 20'd699051;
    localparam logic [CALC_W-1:0] DIV3_BIAS = 20'd65536;
    localparam logic [CALC_W-1:0] DIV3_OFS  = 20'd196608;
    localparam logic [31:0]       LFSR_TAPS = 32'h8020_0003;

    localparam logic FUNC_GEN  = 1'b0;
    localparam logic FUNC_READ = 1'b1;
    localparam logic KIND_GEN  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [1:0] REG_SIDE_LOG   = 2'd0;
    localparam logic [1:0] REG_MAX_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MIN_HEIGHT = 2'd2;

    typedef enum logic [1:0] {A_CORNER, A_CTR, A_EDGE, A_CELL} addr_sel_t;
    typedef enum logic [1:0] {WD_ZERO, WD_CTR, WD_EDGE} wd_sel_t;
    typedef enum logic [1:0] {W_NONE, W_INIT, W_DESCEND, W_ADVANCE} walk_op_t;

    typedef struct packed {
        logic      in_load;
        logic      lfsr_load;
        logic      lfsr_step;
        walk_op_t  walk_op;
        addr_sel_t addr_sel;
        logic [1:0] idx;
        logic      we;
        wd_sel_t   wd_sel;
        logic      shift_corner;
        logic      ctr_sum;
        logic      ctr_cap;
        logic      mod_start;
        logic      edge_sum;
        logic      edge_mul;
        logic      out_load;
        logic      out_kind;
    } cmd_t;

    typedef struct packed {
        logic at_top;
        logic lvl_gt1;
        logic digit_last;
        logic side_zero;
        logic mod_busy;
    } status_t;

    function automatic logic signed [HEIGHT_W-1:0] clamp_h(
        input logic signed [CALC_W-1:0] v,
        input logic signed [CALC_W-1:0] hi,
        input logic signed [CALC_W-1:0] lo
    );
        logic signed [CALC_W-1:0] t;
        t = v;
        if (t > hi)
        begin
            t = hi;
        end
        if (t < lo)
        begin
            t = lo;
        end
        return t[HEIGHT_W-1:0];
    endfunction

    function automatic logic [31:0] lfsr_adv(input logic [31:0] l);
        logic [31:0] t;
        t = l >> 1;
        if (l[0])
        begin
            t = t ^ LFSR_TAPS;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/diamond_square_heightmap.sv =====
// Top level of the diamond-square height map generator.
// Depends on dsh_pkg, dsh_ctrl and dsh_dp.
//
// Input channel (in_valid / in_stall) carries one item: func 0 generates the
// whole grid from seed, func 1 reads the height at row, col. Output channel
// (out_valid / out_stall) returns exactly one item per input item: kind 0
// with height 0 once generation ends, or kind 1 with the stored height (0 outside the grid).
// The user must write registers side_log, max_height, min_height through cfg_we,
// cfg_index, cfg_data only while the block is idle; the block does not enforce this.
// Items are taken one at a time; in_stall is high while an item is in work.
// A read issues the RAM address, then loads the registered RAM read data into
// the output register once that register is free, and returns to idle.
// A generate walks every square depth-first; each square reads its 4 corners,
// writes the centre, then writes each of its edges, each edge waiting on the
// bit-serial remainder unit for its noise draw.
// A finished result waits in the output register while out_stall is high;
// the next item is still accepted, and holds before its own result if the
// register is still full. Reset clears the control state, loads the LFSR
// with one and restores the register defaults; the grid is not cleared.
`default_nettype none

module diamond_square_heightmap #(
    parameter int GRID_LOG = 7
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [1:0]                         cfg_index,
    input  wire logic [8:0]                         cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               func,
    input  wire logic [31:0]                        seed,
    input  wire logic [7:0]                         row,
    input  wire logic [7:0]                         col,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    kind,
    output logic signed [dsh_pkg::HEIGHT_W-1:0]     height
);

    dsh_pkg::cmd_t    cmd;
    dsh_pkg::status_t st;

    dsh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .st       (st),
        .cmd      (cmd)
    );

    dsh_dp #(
        .GRID_LOG(GRID_LOG)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .seed     (seed),
        .row      (row),
        .col      (col),
        .cmd      (cmd),
        .st       (st),
        .kind     (kind),
        .height   (height)
    );

endmodule

`default_nettype wire

// ===== rtl/dsh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dsh_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16641
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/dsh_mod.sv =====
// Bit-serial remainder unit, one dividend bit per cycle.
// No dependencies; used by dsh_dp for the noise draw.
`default_nettype none

module dsh_mod #(
    parameter int DW = 32,
    parameter int MW = 9
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [MW-1:0] divisor,
    output logic               busy,
    output logic      [MW-1:0] rem
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] shf_reg;
    logic [MW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [MW:0]   trial;
    logic [MW-1:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, shf_reg[DW-1]};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = MW'(trial - {1'b0, divisor});
        end
        else
        begin
            rem_next = trial[MW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shf_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            shf_reg <= shf_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/dsh_ctrl.sv =====
// Sequencer of the height map generator: item handshake, square walk, output slot.
// Depends on dsh_pkg and diamond_square_heightmap_macros.svh.
`default_nettype none
`include "diamond_square_heightmap_macros.svh"

module dsh_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             func,
    output logic                  out_valid,
    input  wire logic             out_stall,
    input  wire dsh_pkg::status_t st,
    output dsh_pkg::cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT_WR, S_SQ_RD, S_SQ_CAP, S_CTR_SUM, S_CTR_WR,
        S_N_STEP, S_N_START, S_N_WAIT, S_E_SUM, S_E_MUL, S_E_WR,
        S_WALK, S_FINISH, S_RD_ISSUE, S_RD_WAIT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    cnt_next    = 2'd0;
                    if (func == dsh_pkg::FUNC_GEN)
                    begin
                        cmd.lfsr_load = 1'b1;
                        cmd.walk_op   = dsh_pkg::W_INIT;
                        state_next    = S_INIT_WR;
                    end
                    else
                    begin
                        state_next = S_RD_ISSUE;
                    end
                end
            end
            S_INIT_WR:
            begin
                cmd.addr_sel = dsh_pkg::A_CORNER;
                cmd.idx      = cnt_reg;
                cmd.we       = 1'b1;
                cmd.wd_sel   = dsh_pkg::WD_ZERO;
                cnt_next     = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = st.side_zero ? S_FINISH : S_SQ_RD;
                end
            end
            S_SQ_RD:
            begin
                cmd.addr_sel     = dsh_pkg::A_CORNER;
                cmd.idx          = cnt_reg;
                cmd.shift_corner = (cnt_reg != 2'd0);
                cnt_next         = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = S_SQ_CAP;
                end
            end
            S_SQ_CAP:
            begin
                cmd.shift_corner = 1'b1;
                state_next       = S_CTR_SUM;
            end
            S_CTR_SUM:
            begin
                cmd.ctr_sum = 1'b1;
                state_next  = S_CTR_WR;
            end
            S_CTR_WR:
            begin
                cmd.addr_sel = dsh_pkg::A_CTR;
                cmd.we       = 1'b1;
                cmd.wd_sel   = dsh_pkg::WD_CTR;
                cmd.ctr_cap  = 1'b1;
                cnt_next     = 2'd0;
                state_next   = S_N_STEP;
            end
            S_N_STEP:
            begin
                cmd.lfsr_step = 1'b1;
                state_next    = S_N_START;
            end
            S_N_START:
            begin
                cmd.mod_start = 1'b1;
                state_next    = S_N_WAIT;
            end
            S_N_WAIT:
            begin
                if (!st.mod_busy)
                begin
                    state_next = S_E_SUM;
                end
            end
            S_E_SUM:
            begin
                cmd.edge_sum = 1'b1;
                cmd.idx      = cnt_reg;
                state_next   = S_E_MUL;
            end
            S_E_MUL:
            begin
                cmd.edge_mul = 1'b1;
                state_next   = S_E_WR;
            end
            S_E_WR:
            begin
                cmd.addr_sel = dsh_pkg::A_EDGE;
                cmd.idx      = cnt_reg;
                cmd.we       = 1'b1;
                cmd.wd_sel   = dsh_pkg::WD_EDGE;
                cnt_next     = cnt_reg + 2'd1;
                if (cnt_reg != 2'd3)
                begin
                    state_next = S_N_STEP;
                end
                else if (st.lvl_gt1)
                begin
                    cmd.walk_op = dsh_pkg::W_DESCEND;
                    state_next  = S_SQ_RD;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cnt_next = 2'd0;
                if (st.at_top)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.walk_op = dsh_pkg::W_ADVANCE;
                    if (!st.digit_last)
                    begin
                        state_next = S_SQ_RD;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_kind   = dsh_pkg::KIND_GEN;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RD_ISSUE:
            begin
                cmd.addr_sel = dsh_pkg::A_CELL;
                state_next   = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                cmd.addr_sel = dsh_pkg::A_CELL;
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_kind   = dsh_pkg::KIND_READ;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    `DSH_CHK_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "idle after accept")
    `DSH_CHK_NOW(a_no_overwrite, out_valid && out_stall, !cmd.out_load, "result overwritten")
    `DSH_CHK_NOW(a_mod_start_free, cmd.mod_start, !st.mod_busy, "remainder unit restarted")
    `DSH_CHK_NOW(a_busy_in_wait, st.mod_busy, state_reg == S_N_WAIT, "remainder unit orphaned")

endmodule

`default_nettype wire

// ===== rtl/dsh_dp.sv =====
// Datapath of the height map generator: registers, walk position, LFSR, grid RAM.
// Depends on dsh_pkg, dsh_ram and dsh_mod.
`default_nettype none

module dsh_dp #(
    parameter int GRID_LOG = 7
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [8:0]                          cfg_data,
    input  wire logic [31:0]                         seed,
    input  wire logic [7:0]                          row,
    input  wire logic [7:0]                          col,
    input  wire dsh_pkg::cmd_t                       cmd,
    output dsh_pkg::status_t                         st,
    output logic                                     kind,
    output logic signed [dsh_pkg::HEIGHT_W-1:0]      height
);

    localparam int DIM     = (1 << GRID_LOG) + 1;
    localparam int DEPTH   = DIM * DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COORD_W = GRID_LOG + 1;
    localparam int CMP_W   = (COORD_W > 8) ? COORD_W : 8;
    localparam int LVL_W   = $clog2(GRID_LOG + 1);
    localparam int DIG_N   = 1 << LVL_W;
    localparam int MOD_W   = GRID_LOG + 2;
    localparam int HW      = dsh_pkg::HEIGHT_W;
    localparam int CW      = dsh_pkg::CALC_W;

    logic [2:0]        side_log_reg;
    logic [7:0]        max_reg;
    logic signed [8:0] min_reg;

    logic [CMP_W-1:0]   row_reg, col_reg;
    logic [31:0]        lfsr_reg;
    logic [LVL_W-1:0]   lvl_reg;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic [1:0]         digit_reg [DIG_N];

    logic signed [HW-1:0] ca_reg, cb_reg, cc_reg, cd_reg, c_reg;
    logic signed [CW-1:0] sum_reg;
    logic [dsh_pkg::ESUM_W-1:0] esum_reg;
    logic [dsh_pkg::ESUM_W+dsh_pkg::RCP_W-1:0] prod_reg;
    logic                 kind_reg;
    logic signed [HW-1:0] height_reg;

    logic [LVL_W-1:0]   eff_l;
    logic [COORD_W-1:0] step, half;
    logic [COORD_W-1:0] ar, ac;
    logic [ADDR_W-1:0]  addr;
    logic signed [HW-1:0] wdata, rdata, pv, qv;
    logic signed [CW-1:0] hi_q, lo_q, ctr_v, edge_v, esum_v, noise_q;
    logic [dsh_pkg::QUOT_W-1:0] quot;
    logic [MOD_W-1:0]   rtab [DIG_N];
    logic [MOD_W-1:0]   r_cur, divisor, rem;
    logic               mod_busy;
    logic signed [MOD_W+5:0] nz;
    logic signed [dsh_pkg::NOISE_W-1:0] noise;
    logic signed [HW-1:0] ctr_c;
    logic [CMP_W-1:0]   lim;
    logic               in_range;

    for (genvar gk = 0; gk < DIG_N; gk++)
    begin : g_rtab
        localparam int RV = ((1 << gk) + 1) / 3 + 1;
        assign rtab[gk] = MOD_W'(RV);
    end

    always_comb
    begin
        if (int'(side_log_reg) > GRID_LOG)
        begin
            eff_l = LVL_W'(GRID_LOG);
        end
        else
        begin
            eff_l = LVL_W'(side_log_reg);
        end
    end

    assign step = COORD_W'(1) << lvl_reg;
    assign half = step >> 1;

    assign st.at_top     = (lvl_reg == eff_l);
    assign st.lvl_gt1    = (lvl_reg > LVL_W'(1));
    assign st.digit_last = (digit_reg[lvl_reg] == 2'd3);
    assign st.side_zero  = (eff_l == '0);
    assign st.mod_busy   = mod_busy;

    always_comb
    begin
        ar = x_reg;
        ac = y_reg;
        case (cmd.addr_sel)
            dsh_pkg::A_CORNER:
            begin
                ar = cmd.idx[0] ? x_reg + step : x_reg;
                ac = cmd.idx[1] ? y_reg + step : y_reg;
            end
            dsh_pkg::A_CTR:
            begin
                ar = x_reg + half;
                ac = y_reg + half;
            end
            dsh_pkg::A_EDGE:
            begin
                case (cmd.idx)
                    2'd0:
                    begin
                        ar = x_reg + half;
                        ac = y_reg;
                    end
                    2'd1:
                    begin
                        ar = x_reg + step;
                        ac = y_reg + half;
                    end
                    2'd2:
                    begin
                        ar = x_reg;
                        ac = y_reg + half;
                    end
                    default:
                    begin
                        ar = x_reg + half;
                        ac = y_reg + step;
                    end
                endcase
            end
            dsh_pkg::A_CELL:
            begin
                ar = row_reg[COORD_W-1:0];
                ac = col_reg[COORD_W-1:0];
            end
            default:
            begin
                ar = x_reg;
                ac = y_reg;
            end
        endcase
        addr = (ADDR_W'(ar) << GRID_LOG) + ADDR_W'(ar) + ADDR_W'(ac);
    end

    assign hi_q = {4'b0, max_reg, 8'b0};
    assign lo_q = {{3{min_reg[8]}}, min_reg, 8'b0};

    assign ctr_v = sum_reg >>> 2;
    assign ctr_c = dsh_pkg::clamp_h(ctr_v, hi_q, lo_q);

    always_comb
    begin
        case (cmd.idx)
            2'd0:
            begin
                pv = ca_reg;
                qv = cb_reg;
            end
            2'd2:
            begin
                pv = ca_reg;
                qv = cc_reg;
            end
            default:
            begin
                pv = cc_reg;
                qv = cd_reg;
            end
        endcase
        esum_v = CW'(pv) + CW'(c_reg) + CW'(qv) + dsh_pkg::DIV3_OFS;
    end

    assign r_cur   = rtab[lvl_reg];
    assign divisor = {r_cur[MOD_W-2:0], 1'b0};

    always_comb
    begin
        nz = $signed({6'b0, rem}) - $signed({6'b0, r_cur});
        if (nz > $signed((MOD_W + 6)'(dsh_pkg::NOISE_LIM)))
        begin
            noise = dsh_pkg::NOISE_W'(dsh_pkg::NOISE_LIM);
        end
        else if (nz < -$signed((MOD_W + 6)'(dsh_pkg::NOISE_LIM)))
        begin
            noise = -dsh_pkg::NOISE_W'(dsh_pkg::NOISE_LIM);
        end
        else
        begin
            noise = nz[dsh_pkg::NOISE_W-1:0];
        end
    end

    assign noise_q = {{(CW - dsh_pkg::NOISE_W - 8){noise[dsh_pkg::NOISE_W-1]}}, noise, 8'b0};
    assign quot    = prod_reg[dsh_pkg::RCP_SH +: dsh_pkg::QUOT_W];
    assign edge_v  = CW'(quot) - dsh_pkg::DIV3_BIAS + noise_q;

    always_comb
    begin
        case (cmd.wd_sel)
            dsh_pkg::WD_CTR:  wdata = ctr_c;
            dsh_pkg::WD_EDGE: wdata = dsh_pkg::clamp_h(edge_v, hi_q, lo_q);
            default:          wdata = '0;
        endcase
    end

    assign lim      = CMP_W'(1) << eff_l;
    assign in_range = (row_reg <= lim) && (col_reg <= lim);

    dsh_ram #(
        .WIDTH(HW),
        .DEPTH(DEPTH)
    ) u_grid (
        .clk  (clk),
        .we   (cmd.we),
        .waddr(addr),
        .wdata(wdata),
        .raddr(addr),
        .rdata(rdata)
    );

    dsh_mod #(
        .DW(32),
        .MW(MOD_W)
    ) u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mod_start),
        .dividend(lfsr_reg),
        .divisor (divisor),
        .busy    (mod_busy),
        .rem     (rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_log_reg <= 3'd7;
            max_reg      <= 8'd129;
            min_reg      <= -9'sd2;
            lfsr_reg     <= 32'd1;
            lvl_reg      <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            for (int i = 0; i < DIG_N; i++)
            begin
                digit_reg[i] <= 2'd0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dsh_pkg::REG_SIDE_LOG:   side_log_reg <= cfg_data[2:0];
                    dsh_pkg::REG_MAX_HEIGHT: max_reg      <= cfg_data[7:0];
                    dsh_pkg::REG_MIN_HEIGHT: min_reg      <= cfg_data;
                    default:                 ;
                endcase
            end
            if (cmd.lfsr_load)
            begin
                lfsr_reg <= (seed == 32'd0) ? 32'd1 : seed;
            end
            else if (cmd.lfsr_step)
            begin
                lfsr_reg <= dsh_pkg::lfsr_adv(lfsr_reg);
            end
            case (cmd.walk_op)
                dsh_pkg::W_INIT:
                begin
                    lvl_reg <= eff_l;
                    x_reg   <= '0;
                    y_reg   <= '0;
                end
                dsh_pkg::W_DESCEND:
                begin
                    lvl_reg                     <= lvl_reg - 1'b1;
                    digit_reg[lvl_reg - 1'b1]   <= 2'd0;
                end
                dsh_pkg::W_ADVANCE:
                begin
                    case (digit_reg[lvl_reg])
                        2'd0:
                        begin
                            digit_reg[lvl_reg] <= 2'd1;
                            x_reg              <= x_reg + step;
                        end
                        2'd1:
                        begin
                            digit_reg[lvl_reg] <= 2'd2;
                            x_reg              <= x_reg - step;
                            y_reg              <= y_reg + step;
                        end
                        2'd2:
                        begin
                            digit_reg[lvl_reg] <= 2'd3;
                            x_reg              <= x_reg + step;
                        end
                        default:
                        begin
                            x_reg   <= x_reg - step;
                            y_reg   <= y_reg - step;
                            lvl_reg <= lvl_reg + 1'b1;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            row_reg <= CMP_W'(row);
            col_reg <= CMP_W'(col);
        end
        if (cmd.shift_corner)
        begin
            cd_reg <= rdata;
            cc_reg <= cd_reg;
            cb_reg <= cc_reg;
            ca_reg <= cb_reg;
        end
        if (cmd.ctr_sum)
        begin
            sum_reg <= CW'(ca_reg) + CW'(cb_reg) + CW'(cc_reg) + CW'(cd_reg);
        end
        if (cmd.ctr_cap)
        begin
            c_reg <= ctr_c;
        end
        if (cmd.edge_sum)
        begin
            esum_reg <= esum_v[dsh_pkg::ESUM_W-1:0];
        end
        if (cmd.edge_mul)
        begin
            prod_reg <= esum_reg * dsh_pkg::RECIP3;
        end
        if (cmd.out_load)
        begin
            kind_reg <= cmd.out_kind;
            if (cmd.out_kind == dsh_pkg::KIND_READ && in_range)
            begin
                height_reg <= rdata;
            end
            else
            begin
                height_reg <= '0;
            end
        end
    end

    assign kind   = kind_reg;
    assign height = height_reg;

endmodule

`default_nettype wire
